// File: src/mtco_pkg.sv
// Package: shared types and constants of the multi-timer compare/overflow block.
`default_nettype none

package mtco_pkg;

	localparam int MAX_TIMERS = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CMP_W      = 16;
	localparam int OUT_CNT_W  = 16;
	localparam int SRC_W      = 2;

	// register map
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CMP_BASE  = 3'd4;

	typedef enum logic [SRC_W-1:0] {
		CLK_BUS    = 2'd0,
		CLK_BUS16  = 2'd1,
		CLK_BUS256 = 2'd2,
		CLK_HBLANK = 2'd3
	} clock_source_t;

	typedef struct packed {
		logic          zero_return;
		logic          ovf_irq;
		logic          cmp_irq;
		logic          enable;
		clock_source_t clk_sel;
	} mode_t;

	localparam int MODE_W = $bits(mode_t);

	typedef struct packed {
		mode_t              mode;
		logic [CMP_W-1:0]   compare;
	} timer_cfg_t;

endpackage

`default_nettype wire

// File: src/mtco_if.sv
// Interfaces: clock-event channel and result channel.
`default_nettype none

interface mtco_src_if;
	logic                         valid;
	logic                         ready;
	logic [mtco_pkg::SRC_W-1:0]   clock_source;

	modport source (output valid, output clock_source, input ready);
	modport sink   (input valid, input clock_source, output ready);
endinterface

interface mtco_res_if;
	logic                             valid;
	logic                             ready;
	logic [mtco_pkg::MAX_TIMERS-1:0]  irq_status;
	logic [mtco_pkg::OUT_CNT_W-1:0]   count_out0;
	logic [mtco_pkg::OUT_CNT_W-1:0]   count_out1;
	logic [mtco_pkg::OUT_CNT_W-1:0]   count_out2;
	logic [mtco_pkg::OUT_CNT_W-1:0]   count_out3;

	modport source (output valid, output irq_status, output count_out0, output count_out1,
		output count_out2, output count_out3, input ready);
	modport sink   (input valid, input irq_status, input count_out0, input count_out1,
		input count_out2, input count_out3, output ready);
endinterface

`default_nettype wire

// File: src/mtco_cfg_regs.sv
// Configuration register file: mode and compare per timer.
`default_nettype none

module mtco_cfg_regs #(
	parameter int NUM_TIMERS = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [mtco_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire logic [mtco_pkg::CFG_DATA_W-1:0]   wr_data,
	output mtco_pkg::timer_cfg_t                   cfg [NUM_TIMERS]
);

	for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_tmr
		mtco_pkg::mode_t                 mode_q;
		logic [mtco_pkg::CMP_W-1:0]      compare_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mode_q    <= '0;
				compare_q <= '0;
			end else if (wr_en) begin
				if (wr_index == mtco_pkg::CFG_MODE_BASE + mtco_pkg::CFG_IDX_W'(t))
					mode_q <= mtco_pkg::mode_t'(wr_data[mtco_pkg::MODE_W-1:0]);
				if (wr_index == mtco_pkg::CFG_CMP_BASE + mtco_pkg::CFG_IDX_W'(t))
					compare_q <= wr_data[mtco_pkg::CMP_W-1:0];
			end
		end

		assign cfg[t].mode    = mode_q;
		assign cfg[t].compare = compare_q;
	end

endmodule

`default_nettype wire

// File: src/mtco_timer_slice.sv
// One timer: count and interrupt bit, updated on a matching clock event.
`default_nettype none

module mtco_timer_slice #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          advance,
	input  wire logic [mtco_pkg::SRC_W-1:0]    clock_source,
	input  mtco_pkg::timer_cfg_t               cfg,
	output logic [COUNT_BITS-1:0]              count_nxt,
	output logic                               irq_nxt
);

	localparam int WIDE_W = (COUNT_BITS > mtco_pkg::CMP_W) ? COUNT_BITS : mtco_pkg::CMP_W;

	logic [COUNT_BITS-1:0] count_q;
	logic                  irq_q;
	logic [COUNT_BITS-1:0] inc;
	logic                  hit;
	logic                  wrapped;
	logic                  at_cmp;

	always_comb begin
		hit     = cfg.mode.enable && (cfg.mode.clk_sel == mtco_pkg::clock_source_t'(clock_source));
		inc     = count_q + COUNT_BITS'(1);
		wrapped = (inc == '0);
		at_cmp  = WIDE_W'(inc) >= WIDE_W'(cfg.compare);
		if (hit) begin
			irq_nxt   = (cfg.mode.cmp_irq && at_cmp) || (cfg.mode.ovf_irq && wrapped);
			count_nxt = (cfg.mode.zero_return && at_cmp) ? '0 : inc;
		end else begin
			irq_nxt   = irq_q;
			count_nxt = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			irq_q   <= 1'b0;
		end else if (advance) begin
			count_q <= count_nxt;
			irq_q   <= irq_nxt;
		end
	end

endmodule

`default_nettype wire

// File: src/multi_timer_compare_overflow_top.sv
// Top level of the four-timer compare/overflow block.
//
// Usage:
//   event_ch carries one clock event per transaction (clock_source: bus clock,
//   bus/16, bus/256 or horizontal blank). Every enabled timer whose clock
//   select matches counts once; result_ch returns one transaction per event
//   with the interrupt bits and all timer counts after that event.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle:
//   indexes 0..3 are timer modes, 4..7 compare values.
// Pipeline:
//   An event is taken into the input register (valid_s1, src_s1); the timer
//   update then loads the counts and interrupt bits into the output register,
//   which drives result_ch.valid. One event is accepted every cycle while
//   result_ch is not stalled; the timer update is a single increment,
//   compare and select per timer between the two registers.
// Reset:
//   arst_n clears counts, interrupt bits, configuration and both valid flags.
// Stall:
//   A held result keeps its payload; one more event is taken into the input
//   register, after which event_ch.ready drops until result_ch.ready returns.
`default_nettype none

module multi_timer_compare_overflow_top #(
	parameter int NUM_TIMERS = 4,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	mtco_src_if.sink                               event_ch,
	mtco_res_if.source                             result_ch,
	input  wire logic                              cfg_wr_en,
	input  wire logic [mtco_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mtco_pkg::CFG_DATA_W-1:0]   cfg_data
);

	mtco_pkg::timer_cfg_t cfg [NUM_TIMERS];

	logic                              valid_s1;
	logic [mtco_pkg::SRC_W-1:0]        src_s1;
	logic                              advance;

	logic                              out_valid_q;
	logic [mtco_pkg::MAX_TIMERS-1:0]   irq_q;
	logic [mtco_pkg::OUT_CNT_W-1:0]    count_q [mtco_pkg::MAX_TIMERS];

	logic [mtco_pkg::MAX_TIMERS-1:0]   irq_nxt;
	logic [mtco_pkg::OUT_CNT_W-1:0]    count_nxt [mtco_pkg::MAX_TIMERS];

	mtco_cfg_regs #(.NUM_TIMERS(NUM_TIMERS)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance        = valid_s1 && (!out_valid_q || result_ch.ready);
	assign event_ch.ready = !valid_s1 || !out_valid_q || result_ch.ready;

	for (genvar t = 0; t < mtco_pkg::MAX_TIMERS; t++) begin : g_tmr
		if (t < NUM_TIMERS) begin : g_on
			logic [COUNT_BITS-1:0] cnt;
			logic                  irq;

			mtco_timer_slice #(.COUNT_BITS(COUNT_BITS)) u_slice (
				.clk          (clk),
				.arst_n       (arst_n),
				.advance      (advance),
				.clock_source (src_s1),
				.cfg          (cfg[t]),
				.count_nxt    (cnt),
				.irq_nxt      (irq)
			);

			assign count_nxt[t] = mtco_pkg::OUT_CNT_W'(cnt);
			assign irq_nxt[t]   = irq;
		end else begin : g_off
			assign count_nxt[t] = '0;
			assign irq_nxt[t]   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (event_ch.ready)
				valid_s1 <= event_ch.valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (result_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (event_ch.ready && event_ch.valid)
			src_s1 <= event_ch.clock_source;
		if (advance) begin
			irq_q   <= irq_nxt;
			count_q <= count_nxt;
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.irq_status = irq_q;
	assign result_ch.count_out0 = count_q[0];
	assign result_ch.count_out1 = count_q[1];
	assign result_ch.count_out2 = count_q[2];
	assign result_ch.count_out3 = count_q[3];

endmodule

`default_nettype wire

// File: src/mtco_checker.sv
// Port checker for the multi-timer block, bound to the top level.
`default_nettype none

module mtco_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [mtco_pkg::MAX_TIMERS-1:0]   irq_status,
	input wire logic [mtco_pkg::OUT_CNT_W-1:0]    count_out0
);

	logic [2:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(irq_status) && $stable(count_out0))
		else $error("stalled result changed");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result without a pending event");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd2)
		else $error("more events in flight than pipeline slots");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 3'd0 |-> in_ready)
		else $error("input stalled with nothing in flight");

endmodule

bind multi_timer_compare_overflow_top mtco_checker u_mtco_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (event_ch.valid),
	.in_ready   (event_ch.ready),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.irq_status (result_ch.irq_status),
	.count_out0 (result_ch.count_out0)
);

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Testbench for the four-timer compare/overflow block: directed table, no-idle run, random phases.
module testbench;

	localparam int CYCLE_LIMIT      = 500_000;
	localparam int RANDOM_PHASES    = 8;
	localparam int EVENTS_PER_PHASE = 92;
	localparam int LONG_RUN_EVENTS  = 200;
	localparam int HOLD_OFF_CYCLES  = 64;
	localparam int PRESSURE_PHASE   = 3;
	localparam int MAX_PRINTED      = 30;

	// mode register fields as they sit in cfg_data
	localparam logic [mtco_pkg::CFG_DATA_W-1:0] M_EN   = 16'h0004;
	localparam logic [mtco_pkg::CFG_DATA_W-1:0] M_CMP  = 16'h0008;
	localparam logic [mtco_pkg::CFG_DATA_W-1:0] M_OVF  = 16'h0010;
	localparam logic [mtco_pkg::CFG_DATA_W-1:0] M_ZRET = 16'h0020;
	localparam logic [mtco_pkg::CFG_DATA_W-1:0] M_JUNK = 16'hFFC0;

	typedef struct packed {
		logic [mtco_pkg::MAX_TIMERS-1:0]                         irq;
		logic [mtco_pkg::MAX_TIMERS-1:0][mtco_pkg::OUT_CNT_W-1:0] counts;
	} timer_snapshot_t;

	typedef enum logic {ROW_WRITE, ROW_EVENT} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		logic [mtco_pkg::CFG_IDX_W-1:0]  idx;
		logic [mtco_pkg::CFG_DATA_W-1:0] data;
		mtco_pkg::clock_source_t         src;
		logic [mtco_pkg::MAX_TIMERS-1:0] irq;
		logic [mtco_pkg::OUT_CNT_W-1:0]  c0;
		logic [mtco_pkg::OUT_CNT_W-1:0]  c1;
		logic [mtco_pkg::OUT_CNT_W-1:0]  c2;
		logic [mtco_pkg::OUT_CNT_W-1:0]  c3;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 25;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_EVENT, mtco_pkg::CFG_MODE_BASE, 16'h0000, mtco_pkg::CLK_BUS,
			4'h0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{ROW_EVENT, mtco_pkg::CFG_MODE_BASE, 16'h0000, mtco_pkg::CLK_HBLANK,
			4'h0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{ROW_WRITE, mtco_pkg::CFG_MODE_BASE, M_EN | M_CMP | 16'(mtco_pkg::CLK_BUS),
			mtco_pkg::CLK_BUS, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{ROW_WRITE, mtco_pkg::CFG_CMP_BASE, 16'd2,
			mtco_pkg::CLK_BUS, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{ROW_WRITE, mtco_pkg::CFG_MODE_BASE + 3'd1, M_EN | M_OVF | 16'(mtco_pkg::CLK_BUS16),
			mtco_pkg::CLK_BUS, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{ROW_WRITE, mtco_pkg::CFG_CMP_BASE + 3'd1, 16'd0,
			mtco_pkg::CLK_BUS, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{ROW_WRITE, mtco_pkg::CFG_MODE_BASE + 3'd2,
			M_EN | M_CMP | M_ZRET | 16'(mtco_pkg::CLK_BUS256),
			mtco_pkg::CLK_BUS, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{ROW_WRITE, mtco_pkg::CFG_CMP_BASE + 3'd2, 16'd1,
			mtco_pkg::CLK_BUS, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{ROW_WRITE, mtco_pkg::CFG_MODE_BASE + 3'd3,
			M_EN | M_CMP | M_OVF | M_ZRET | 16'(mtco_pkg::CLK_HBLANK),
			mtco_pkg::CLK_BUS, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{ROW_WRITE, mtco_pkg::CFG_CMP_BASE + 3'd3, 16'hFFFF,
			mtco_pkg::CLK_BUS, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{ROW_EVENT, mtco_pkg::CFG_MODE_BASE, 16'h0000, mtco_pkg::CLK_BUS,
			4'h0, 16'd1, 16'd0, 16'd0, 16'd0},
		'{ROW_EVENT, mtco_pkg::CFG_MODE_BASE, 16'h0000, mtco_pkg::CLK_BUS,
			4'h1, 16'd2, 16'd0, 16'd0, 16'd0},
		'{ROW_EVENT, mtco_pkg::CFG_MODE_BASE, 16'h0000, mtco_pkg::CLK_BUS256,
			4'h5, 16'd2, 16'd0, 16'd0, 16'd0},
		'{ROW_EVENT, mtco_pkg::CFG_MODE_BASE, 16'h0000, mtco_pkg::CLK_BUS16,
			4'h5, 16'd2, 16'd1, 16'd0, 16'd0},
		'{ROW_EVENT, mtco_pkg::CFG_MODE_BASE, 16'h0000, mtco_pkg::CLK_HBLANK,
			4'h5, 16'd2, 16'd1, 16'd0, 16'd1},
		'{ROW_WRITE, mtco_pkg::CFG_MODE_BASE, 16'h0000,
			mtco_pkg::CLK_BUS, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{ROW_EVENT, mtco_pkg::CFG_MODE_BASE, 16'h0000, mtco_pkg::CLK_BUS,
			4'h5, 16'd2, 16'd1, 16'd0, 16'd1},
		'{ROW_WRITE, mtco_pkg::CFG_MODE_BASE + 3'd1,
			M_EN | M_CMP | M_ZRET | 16'(mtco_pkg::CLK_BUS16),
			mtco_pkg::CLK_BUS, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{ROW_EVENT, mtco_pkg::CFG_MODE_BASE, 16'h0000, mtco_pkg::CLK_BUS16,
			4'h7, 16'd2, 16'd0, 16'd0, 16'd1},
		'{ROW_EVENT, mtco_pkg::CFG_MODE_BASE, 16'h0000, mtco_pkg::CLK_HBLANK,
			4'h7, 16'd2, 16'd0, 16'd0, 16'd2},
		'{ROW_WRITE, mtco_pkg::CFG_CMP_BASE + 3'd3, 16'd2,
			mtco_pkg::CLK_BUS, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{ROW_EVENT, mtco_pkg::CFG_MODE_BASE, 16'h0000, mtco_pkg::CLK_HBLANK,
			4'hF, 16'd2, 16'd0, 16'd0, 16'd0},
		'{ROW_WRITE, mtco_pkg::CFG_MODE_BASE + 3'd2, M_JUNK | M_EN | 16'(mtco_pkg::CLK_BUS256),
			mtco_pkg::CLK_BUS, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{ROW_EVENT, mtco_pkg::CFG_MODE_BASE, 16'h0000, mtco_pkg::CLK_BUS256,
			4'hB, 16'd2, 16'd0, 16'd1, 16'd0},
		'{ROW_EVENT, mtco_pkg::CFG_MODE_BASE, 16'h0000, mtco_pkg::CLK_BUS16,
			4'hB, 16'd2, 16'd0, 16'd1, 16'd0}
	};

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [mtco_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mtco_pkg::CFG_DATA_W-1:0] cfg_data;

	mtco_src_if ev_ch();
	mtco_res_if res_ch();

	multi_timer_compare_overflow_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.event_ch  (ev_ch),
		.result_ch (res_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predicted timer state
	mtco_pkg::mode_t                 tmr_mode  [mtco_pkg::MAX_TIMERS];
	logic [mtco_pkg::CMP_W-1:0]      tmr_cmp   [mtco_pkg::MAX_TIMERS];
	logic [mtco_pkg::OUT_CNT_W-1:0]  tmr_count [mtco_pkg::MAX_TIMERS];
	logic [mtco_pkg::MAX_TIMERS-1:0] tmr_irq;

	timer_snapshot_t pending_q[$];

	bit gaps_on        = 1'b1;
	bit pressure_armed = 1'b0;
	bit pressure_done  = 1'b0;

	int mismatches  = 0;
	int checked     = 0;
	int cycles      = 0;
	int reg_writes  = 0;
	int wraps_seen  = 0;
	int hits_seen   = 0;
	int directed_n  = 0;
	int long_n      = 0;
	int random_n    = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d transactions still pending",
				cycles, pending_q.size());
			$display("FAILURE");
			$finish;
		end
	end

	function automatic timer_snapshot_t advance_timers(input mtco_pkg::clock_source_t src);
		timer_snapshot_t                snap;
		logic [mtco_pkg::OUT_CNT_W-1:0] nxt;
		logic                           hit;
		for (int t = 0; t < mtco_pkg::MAX_TIMERS; t++) begin
			if (tmr_mode[t].enable && tmr_mode[t].clk_sel == src) begin
				nxt = tmr_count[t] + 1'b1;
				hit = nxt >= tmr_cmp[t];
				if (nxt == '0)
					wraps_seen++;
				if (hit)
					hits_seen++;
				tmr_irq[t] = (tmr_mode[t].cmp_irq && hit) || (tmr_mode[t].ovf_irq && nxt == '0);
				if (tmr_mode[t].zero_return && hit)
					nxt = '0;
				tmr_count[t] = nxt;
			end
			snap.counts[t] = tmr_count[t];
		end
		snap.irq = tmr_irq;
		return snap;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("mismatch @%0t: %s", $realtime, msg);
	endtask

	task automatic put_event(input mtco_pkg::clock_source_t src, input bit use_given,
			input timer_snapshot_t given);
		timer_snapshot_t predicted;
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 32) begin
			ev_ch.valid = 1'b0;
			@(negedge clk);
		end
		ev_ch.valid = 1'b1;
		ev_ch.clock_source = src;
		do @(posedge clk); while (!ev_ch.ready);
		predicted = advance_timers(src);
		pending_q.push_back(use_given ? given : predicted);
	endtask

	task automatic drain_results();
		@(negedge clk);
		ev_ch.valid = 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mtco_pkg::CFG_IDX_W-1:0] idx,
			input logic [mtco_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		if (idx >= mtco_pkg::CFG_CMP_BASE)
			tmr_cmp[2'(idx - mtco_pkg::CFG_CMP_BASE)] = data;
		else
			tmr_mode[2'(idx - mtco_pkg::CFG_MODE_BASE)] =
				mtco_pkg::mode_t'(data[mtco_pkg::MODE_W-1:0]);
		reg_writes++;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic randomise_registers();
		logic [mtco_pkg::CFG_DATA_W-1:0] cmp;
		for (int t = 0; t < mtco_pkg::MAX_TIMERS; t++) begin
			write_reg(mtco_pkg::CFG_MODE_BASE + 3'(t),
				{10'($urandom_range(1023)), 6'($urandom_range(63))});
			case ($urandom_range(3))
				0: cmp = '0;
				1: cmp = '1;
				2: cmp = 16'($urandom_range(12));
				default: cmp = 16'($urandom);
			endcase
			write_reg(mtco_pkg::CFG_CMP_BASE + 3'(t), cmp);
		end
	endtask

	// receiver side: random back-pressure plus one long hold-off
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_armed && !pressure_done) begin
				res_ch.ready = 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
				pressure_done = 1'b1;
			end else begin
				res_ch.ready = !(gaps_on && $urandom_range(99) < 32);
			end
		end
	end

	always @(posedge clk) begin
		timer_snapshot_t got;
		timer_snapshot_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.irq = res_ch.irq_status;
			got.counts[0] = res_ch.count_out0;
			got.counts[1] = res_ch.count_out1;
			got.counts[2] = res_ch.count_out2;
			got.counts[3] = res_ch.count_out3;
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("unexpected transaction irq=%h", got.irq));
			end else begin
				want = pending_q.pop_front();
				checked++;
				if (got.irq !== want.irq)
					report_mismatch($sformatf("irq_status %h, want %h", got.irq, want.irq));
				for (int t = 0; t < mtco_pkg::MAX_TIMERS; t++)
					if (got.counts[t] !== want.counts[t])
						report_mismatch($sformatf("count_out%0d %h, want %h",
							t, got.counts[t], want.counts[t]));
			end
		end
	end

	initial begin
		stim_row_t       row;
		timer_snapshot_t given;
		arst_n = 1'b0;
		ev_ch.valid = 1'b0;
		ev_ch.clock_source = mtco_pkg::CLK_BUS;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int t = 0; t < mtco_pkg::MAX_TIMERS; t++) begin
			tmr_mode[t] = '0;
			tmr_cmp[t] = '0;
			tmr_count[t] = '0;
		end
		tmr_irq = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_WRITE) begin
				drain_results();
				write_reg(row.idx, row.data);
			end else begin
				given.irq = row.irq;
				given.counts[0] = row.c0;
				given.counts[1] = row.c1;
				given.counts[2] = row.c2;
				given.counts[3] = row.c3;
				put_event(row.src, 1'b1, given);
				directed_n++;
			end
		end

		// every timer on the bus clock, no idling on either side
		drain_results();
		gaps_on = 1'b0;
		write_reg(mtco_pkg::CFG_MODE_BASE, M_EN | M_OVF | 16'(mtco_pkg::CLK_BUS));
		write_reg(mtco_pkg::CFG_MODE_BASE + 3'd1, M_EN | M_CMP | 16'(mtco_pkg::CLK_BUS));
		write_reg(mtco_pkg::CFG_CMP_BASE + 3'd1, 16'd150);
		write_reg(mtco_pkg::CFG_MODE_BASE + 3'd2, M_EN | M_ZRET | 16'(mtco_pkg::CLK_BUS));
		write_reg(mtco_pkg::CFG_CMP_BASE + 3'd2, 16'd7);
		write_reg(mtco_pkg::CFG_MODE_BASE + 3'd3,
			M_EN | M_CMP | M_OVF | M_ZRET | 16'(mtco_pkg::CLK_BUS));
		write_reg(mtco_pkg::CFG_CMP_BASE + 3'd3, 16'd50);
		repeat (LONG_RUN_EVENTS) begin
			put_event(mtco_pkg::CLK_BUS, 1'b0, '0);
			long_n++;
		end
		drain_results();
		gaps_on = 1'b1;

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_results();
			randomise_registers();
			if (p == PRESSURE_PHASE)
				pressure_armed = 1'b1;
			repeat (EVENTS_PER_PHASE) begin
				put_event(mtco_pkg::clock_source_t'($urandom_range(3)), 1'b0, '0);
				random_n++;
			end
		end

		@(negedge clk);
		ev_ch.valid = 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("%0d events (%0d table, %0d no-idle run, %0d random), %0d results compared",
			directed_n + long_n + random_n, directed_n, long_n, random_n, checked);
		$display("%0d register writes, %0d counter wraps, %0d compare hits, %0d mismatches",
			reg_writes, wraps_seen, hits_seen, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: files.f
src/mtco_pkg.sv
src/mtco_if.sv
src/mtco_cfg_regs.sv
src/mtco_timer_slice.sv
src/multi_timer_compare_overflow_top.sv
src/mtco_checker.sv
bench/testbench.sv
